@@ rtl/core/min_pq_pkg.sv @@
// Package for the min priority queue: beat payload types, codes and the
// control group that the top level hands to every cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package min_pq_pkg;

   localparam int unsigned FIELD_VALUE_WIDTH = 32;
   localparam int unsigned FIELD_COUNT_WIDTH = 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef struct packed {
      logic                                operation;
      logic signed [FIELD_VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_VALUE_WIDTH-1:0] min_value;
      logic                                is_empty;
      logic [FIELD_COUNT_WIDTH-1:0]        entry_count;
      logic [1:0]                          error_code;
   } rsp_type;

   // Broadcast to every cell of the chain in the cycle of an accepted beat.
   typedef struct packed {
      logic ins;
      logic del;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/min_pq_cell.sv @@
// One cell of the sorted chain: holds a single entry and its valid flag.
// Depends on min_pq_pkg for the control group.
`timescale 1ns / 1ps
`default_nettype none

module min_pq_cell #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire min_pq_pkg::cell_ctl_type      ctl,
   input  wire logic signed [VALUE_WIDTH-1:0] new_value,
   input  wire logic signed [VALUE_WIDTH-1:0] left_data,
   input  wire logic                          left_valid,
   input  wire logic                          left_gt,
   input  wire logic signed [VALUE_WIDTH-1:0] right_data,
   input  wire logic                          right_valid,
   output logic signed [VALUE_WIDTH-1:0]      data_out,
   output logic                               valid_out,
   output logic                               gt_out
);
   import min_pq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] data_ff, data_in;
   logic                          valid_ff, valid_in;
   logic                          gt;

   // The new value belongs at or before this place when it is strictly
   // smaller than what is held here, so equal values stay in arrival order.
   assign gt = !valid_ff || (new_value < data_ff);

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      priority if (ctl.del) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctl.ins && gt) begin
         if (left_gt) begin
            data_in  = left_data;
            valid_in = left_valid;
         end else begin
            data_in  = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign gt_out    = gt;

endmodule

`default_nettype wire

@@ rtl/core/min_priority_queue_top.sv @@
// Top level of the min priority queue: a chain of min_pq_cell instances
// kept in sorted order, an entry counter and the result register.
// Depends on min_pq_pkg and min_pq_cell.
`timescale 1ns / 1ps
`default_nettype none

//   channel   ports                         handshake
//   request   start, busy, req_item         beat taken when start && !busy
//   response  rsp_strobe, rsp_item          beat shown for one cycle, no stall
//
// A request beat is accepted in any cycle with busy low, back to back; its
// response beat appears in the cycle right after the accept edge.
// busy is a register that reset sets; the first edge after reset releases
// clears it for good. Reset is synchronous and empties the chain.
// The receiver cannot stall the response; a new request changes the chain
// only at the edge that ends the current response cycle.
module min_priority_queue_top #(
   parameter int unsigned DEPTH       = 128,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire min_pq_pkg::req_type req_item,
   output logic                     rsp_strobe,
   output min_pq_pkg::rsp_type      rsp_item
);
   import min_pq_pkg::*;

   localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);

   // The chain holds its entries sorted ascending from cell 0. Equal values
   // stay in arrival order, since an insert lands behind every entry that is
   // not larger, so cell 0 always holds the oldest of the minima. In an
   // insert every cell compares the new value with its own entry and
   // then keeps its entry, takes the new value, or takes its left neighbor's
   // entry. A delete shifts every cell one place toward cell 0.

   logic                          accept;
   logic                          full;
   logic                          empty_now;
   cell_ctl_type                  ctl;
   logic signed [VALUE_WIDTH-1:0] new_value;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   err_type                       err_ff, err_in;
   logic                          strobe_ff;
   logic                          busy_ff;

   logic signed [VALUE_WIDTH-1:0] cell_data  [DEPTH];
   logic                          cell_valid [DEPTH];
   logic                          cell_gt    [DEPTH];

   assign accept    = start && !busy_ff;
   assign full      = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty_now = (count_ff == '0);

   // The 32-bit field is sign-extended or cut down to the stored width.
   assign new_value = VALUE_WIDTH'(req_item.value);

   // Work out the broadcast control, the next count and the error code.
   always_comb begin
      ctl      = '0;
      count_in = count_ff;
      err_in   = ERR_OK;
      if (accept) begin
         unique case (op_type'(req_item.operation))
            OP_INSERT: begin
               if (full) begin
                  err_in = ERR_FULL;
               end else begin
                  ctl.ins  = 1'b1;
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            OP_DELETE: begin
               if (empty_now) begin
                  err_in = ERR_EMPTY;
               end else begin
                  ctl.del  = 1'b1;
                  count_in = count_ff - COUNT_WIDTH'(1);
               end
            end
            default: begin
               err_in = ERR_OK;
            end
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_data;
      logic                          left_valid;
      logic                          left_gt;
      logic signed [VALUE_WIDTH-1:0] right_data;
      logic                          right_valid;

      if (i == 0) begin : g_head
         assign left_data  = new_value;
         assign left_valid = 1'b0;
         assign left_gt    = 1'b0;
      end else begin : g_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data  = cell_data[i];
         assign right_valid = 1'b0;
      end else begin : g_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      min_pq_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_value   (new_value),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .left_gt     (left_gt),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data_out    (cell_data[i]),
         .valid_out   (cell_valid[i]),
         .gt_out      (cell_gt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         err_ff    <= ERR_OK;
         strobe_ff <= 1'b0;
         busy_ff   <= 1'b1;
      end else begin
         count_ff  <= count_in;
         err_ff    <= err_in;
         strobe_ff <= accept;
         busy_ff   <= 1'b0;
      end
   end

   // The response reads the chain after the accept edge has updated it, so
   // cell 0 already holds the minimum that this beat leaves behind.
   assign busy                 = busy_ff;
   assign rsp_strobe           = strobe_ff;
   assign rsp_item.min_value   = cell_valid[0] ? FIELD_VALUE_WIDTH'(cell_data[0]) : '0;
   assign rsp_item.is_empty    = !cell_valid[0];
   assign rsp_item.entry_count = FIELD_COUNT_WIDTH'(count_ff);
   assign rsp_item.error_code  = err_ff;

endmodule

`default_nettype wire

@@ rtl/core/min_pq_checker.sv @@
// Port-level checks for min_priority_queue_top, attached by the bind below.
// Depends on min_pq_pkg and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module min_pq_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire min_pq_pkg::req_type req_item,
   input wire logic                rsp_strobe,
   input wire min_pq_pkg::rsp_type rsp_item
);
   import min_pq_pkg::*;

   // Every accepted request beat gets exactly one response beat, next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (rsp_strobe == $past(start && !busy)))
      else $error("response beat does not match an accepted request");

   // An empty queue reports a zero minimum.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.is_empty) |-> (rsp_item.min_value == '0))
      else $error("empty queue reports a nonzero minimum");

   // A rejected delete leaves the queue empty.
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.error_code == ERR_EMPTY)) |-> rsp_item.is_empty)
      else $error("delete error reported on a non-empty queue");

   // A successful delete on a non-empty queue right after a previous
   // response lowers the count by one.
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe) && $past(start && !busy)
       && ($past(req_item.operation) == OP_DELETE)
       && (rsp_item.error_code == ERR_OK))
      |-> (rsp_item.entry_count == $past(rsp_item.entry_count) - 8'd1))
      else $error("delete did not lower the entry count");

endmodule

bind min_priority_queue_top min_pq_checker u_min_pq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

@@ tb/min_priority_queue_top_test.sv @@
// Self-checking testbench for min_priority_queue_top: random insert and delete
// beats are checked against a behavioral queue model kept in arrival order.
// Depends on min_pq_pkg and the RTL of min_priority_queue_top.
`timescale 1ns / 1ps

module min_priority_queue_top_test;

   import min_pq_pkg::*;

   localparam int unsigned QUEUE_DEPTH    = 128;
   localparam int unsigned RANDOM_BEATS   = 950;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 4;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   min_priority_queue_top #(
      .DEPTH       (QUEUE_DEPTH),
      .VALUE_WIDTH (FIELD_VALUE_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Request beats waiting to be driven, and the responses the model predicts
   // for beats the block has already taken, oldest first.
   req_type queued_requests[$];
   rsp_type predicted_responses[$];

   int unsigned beats_planned  = 0;
   int unsigned beats_taken    = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   logic        beat_accepted  = 1'b0;

   // Behavioral copy of the queue. Entries stay in arrival order; the
   // position of the smallest one is tracked so that on a tie the oldest
   // equal entry is the one a delete removes.
   logic signed [FIELD_VALUE_WIDTH-1:0] model_vals[QUEUE_DEPTH];
   int unsigned                         model_count  = 0;
   int unsigned                         model_min_at = 0;

   function automatic rsp_type predict_queue_response(req_type beat);
      rsp_type result;
      result = '0;
      result.error_code = ERR_OK;
      if (beat.operation == OP_INSERT) begin
         if (model_count >= QUEUE_DEPTH) begin
            // A full store drops the value and leaves everything as it was.
            result.error_code = ERR_FULL;
         end else begin
            // Strict compare: an equal newcomer never displaces the minimum.
            if (model_count == 0 || beat.value < model_vals[model_min_at]) begin
               model_min_at = model_count;
            end
            model_vals[model_count] = beat.value;
            model_count++;
         end
      end else begin
         if (model_count == 0) begin
            result.error_code = ERR_EMPTY;
         end else begin
            // Close the gap left by the minimum, then find the new minimum,
            // keeping the first (oldest) of any equal values.
            for (int unsigned i = model_min_at; i + 1 < model_count; i++) begin
               model_vals[i] = model_vals[i + 1];
            end
            model_count--;
            model_min_at = 0;
            for (int unsigned i = 1; i < model_count; i++) begin
               if (model_vals[i] < model_vals[model_min_at]) begin
                  model_min_at = i;
               end
            end
         end
      end
      result.is_empty    = (model_count == 0);
      result.min_value   = (model_count == 0) ? '0 : model_vals[model_min_at];
      result.entry_count = model_count[FIELD_COUNT_WIDTH-1:0];
      return result;
   endfunction

   // Prints one line per mismatch and counts every one of them.
   task automatic report_mismatch(string what, logic [FIELD_VALUE_WIDTH-1:0] got,
                                  logic [FIELD_VALUE_WIDTH-1:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h",
               $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Value mix: many small values so that equal minima are common, the
   // signed extremes, fully random bit patterns and values in -1000..1000.
   function automatic logic signed [FIELD_VALUE_WIDTH-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 25) begin
         return $urandom;
      end
      if (sel < 65) begin
         return int'($urandom_range(7)) - 4;
      end
      if (sel < 80) begin
         case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh8000_0001;
            2: return 32'sh7fff_ffff;
            3: return 32'sh7fff_fffe;
            4: return -1;
            default: return 0;
         endcase
      end
      return int'($urandom_range(2000)) - 1000;
   endfunction

   task automatic add_beat(op_type op, logic signed [FIELD_VALUE_WIDTH-1:0] val);
      req_type beat;
      beat.operation = op;
      beat.value     = val;
      queued_requests.push_back(beat);
      beats_planned++;
   endtask

   // A run of beats in which inserts make up the given share. Deletes carry
   // a random value, which the block must ignore.
   task automatic add_phase(int unsigned length, int unsigned insert_pct);
      for (int unsigned k = 0; k < length; k++) begin
         if ($urandom_range(99) < insert_pct) begin
            add_beat(OP_INSERT, pick_value());
         end else begin
            add_beat(OP_DELETE, $urandom);
         end
      end
   endtask

   // Driver. It changes the request on the falling edge. A beat stays on the
   // port until the monitor has seen it taken; between beats it idles for a
   // random number of cycles, mostly short, now and then long, with bursts
   // of back-to-back beats mixed in. While idle the payload carries noise.
   int unsigned idle_left  = 0;
   int unsigned burst_left = 0;

   always @(negedge clock) begin : driver
      int unsigned roll;
      req_type     noise;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_accepted) begin
         if (idle_left > 0 || queued_requests.size() == 0) begin
            if (idle_left > 0) begin
               idle_left--;
            end
            noise.operation = $urandom_range(1);
            noise.value     = $urandom;
            start    <= 1'b0;
            req_item <= noise;
         end else begin
            start    <= 1'b1;
            req_item <= queued_requests.pop_front();
            if (burst_left > 0) begin
               burst_left--;
               idle_left = 0;
            end else begin
               roll = $urandom_range(99);
               if (roll < 2) begin
                  burst_left = $urandom_range(80, 40);
                  idle_left  = 0;
               end else if (roll < 55) begin
                  idle_left = 0;
               end else if (roll < 88) begin
                  idle_left = $urandom_range(3, 1);
               end else if (roll < 97) begin
                  idle_left = $urandom_range(10, 4);
               end else begin
                  idle_left = $urandom_range(60, 20);
               end
            end
         end
      end
   end

   // Monitor. On the rising edge it checks a response beat against the oldest
   // prediction, then records a request beat taken at this edge. A response
   // always belongs to a request taken at an earlier edge, so the order of
   // the two steps does not matter. It also runs the watchdog, which counts
   // cycles in which neither channel moves a beat.
   always @(posedge clock) begin : monitor
      rsp_type want;
      beat_accepted <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (predicted_responses.size() == 0) begin
               report_mismatch("unexpected response beat", rsp_item.min_value, '0);
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_item.min_value !== want.min_value) begin
                  report_mismatch("min_value", rsp_item.min_value, want.min_value);
               end
               if (rsp_item.is_empty !== want.is_empty) begin
                  report_mismatch("is_empty", rsp_item.is_empty, want.is_empty);
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  report_mismatch("entry_count", rsp_item.entry_count,
                                  want.entry_count);
               end
               if (rsp_item.error_code !== want.error_code) begin
                  report_mismatch("error_code", rsp_item.error_code, want.error_code);
               end
            end
         end
         if (start && !busy) begin
            predicted_responses.push_back(predict_queue_response(req_item));
            beats_taken++;
         end
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("min_priority_queue_top_test: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned random_start;
      int unsigned mix;

      // Directed opening: delete from an empty store, insert into an empty
      // store, the signed extremes, equal minima, draining back to empty and
      // deleting once more, and alternating bit patterns in the value.
      add_beat(OP_DELETE, 32'sh1234_5678);
      add_beat(OP_INSERT, 5);
      add_beat(OP_INSERT, 32'sh7fff_ffff);
      add_beat(OP_INSERT, 32'sh8000_0000);
      add_beat(OP_INSERT, 32'sh8000_0000);
      add_beat(OP_INSERT, 0);
      add_beat(OP_INSERT, -1);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, -1);
      add_beat(OP_INSERT, 3);
      add_beat(OP_INSERT, 3);
      add_beat(OP_DELETE, 32'sh7fff_ffff);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);
      add_beat(OP_INSERT, 32'sh5555_5555);
      add_beat(OP_INSERT, 32'shaaaa_aaaa);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);
      add_beat(OP_DELETE, 0);

      // Random part. It opens by filling the store past full and draining it
      // past empty, so that both error paths see plenty of traffic, then
      // moves through phases that lean toward inserts, deletes or neither.
      random_start = beats_planned;
      add_phase(170, 92);
      add_phase(190, 10);
      while (beats_planned - random_start < RANDOM_BEATS) begin
         mix = $urandom_range(3);
         add_phase($urandom_range(120, 30),
                   (mix == 0) ? 15 : (mix == 3) ? 85 : 50);
      end

      // Reset is held from the start and released on a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_taken < beats_planned || predicted_responses.size() != 0) begin
         @(posedge clock);
      end
      // A drain period catches any stray response beat.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && predicted_responses.size() == 0) begin
         $display("min_priority_queue_top_test: PASS");
      end else begin
         $display("min_priority_queue_top_test: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/min_pq_pkg.sv
rtl/core/min_pq_cell.sv
rtl/core/min_priority_queue_top.sv
rtl/core/min_pq_checker.sv
tb/min_priority_queue_top_test.sv
